FILE: rtl/core/uq7_pkg.sv
package uq7_pkg;

  // Command codes on the input channel
  typedef enum logic [1:0] {
    CMD_QUANT   = 2'd0,
    CMD_DEQUANT = 2'd1,
    CMD_RESCALE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SCALE     = 2'd0,
    REG_BIAS      = 2'd1,
    REG_RECIP     = 2'd2,
    REG_INV_SQ    = 2'd3
  } reg_e;

  localparam logic [31:0] FP_ONE       = 32'h3F80_0000;
  localparam logic [31:0] FP_127       = 32'h42FE_0000;
  localparam logic [31:0] FP_DFLT_NAN  = 32'hFFC0_0000;
  localparam logic [31:0] FP_QUIET_BIT = 32'h0040_0000;
  localparam logic [6:0]  CODE_MAX     = 7'd127;

  // Control that travels beside the data in every stage
  typedef struct packed {
    logic vld;
    cmd_e cmd;
    logic last;
  } side_t;

  // One result transaction
  typedef struct packed {
    logic [31:0] result;
    logic        status;
    logic        last;
  } out_item_t;

  // Leading zeros of a 48-bit word (input known nonzero)
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] cnt;
    cnt = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) begin
        cnt = 6'(47 - i);
      end
    end
    return cnt;
  endfunction

  // Leading zeros of a 28-bit word (input known nonzero)
  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] cnt;
    cnt = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) begin
        cnt = 5'(27 - i);
      end
    end
    return cnt;
  endfunction

  // Round to nearest even and pack; e is the biased exponent (>= 1),
  // m has its leading one at bit 23 unless the value is subnormal.
  function automatic logic [31:0] round_pack(input logic s, input logic [9:0] e,
                                             input logic [23:0] m, input logic g,
                                             input logic st);
    logic        inc;
    logic [24:0] mr;
    logic [9:0]  ef;
    logic [22:0] man;
    logic [7:0]  ex;
    inc = g & (st | m[0]);
    mr  = {1'b0, m} + {24'd0, inc};
    ef  = mr[24] ? e + 10'd1 : e;
    man = mr[24] ? mr[23:1] : mr[22:0];
    ex  = (mr[24] | mr[23]) ? ef[7:0] : 8'd0;
    if (ef >= 10'd255) begin
      return {s, 8'hFF, 23'd0};
    end
    return {s, ex, man};
  endfunction

  // Exact conversion of a signed byte to fp32
  function automatic logic [31:0] i8_to_fp(input logic [7:0] x);
    logic [7:0]  mag;
    logic [2:0]  lz;
    logic [23:0] m;
    mag = x[7] ? 8'(-x) : x;
    lz  = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) begin
        lz = 3'(7 - i);
      end
    end
    m = {mag, 16'd0} << lz;
    if (mag == 8'd0) begin
      return 32'd0;
    end
    return {x[7], 8'(8'd134 - {5'd0, lz}), m[22:0]};
  endfunction

  // nearbyint and clamp to 0..127; NaN maps to the top code
  function automatic logic [6:0] to_code(input logic [31:0] v);
    logic [7:0]  e;
    logic [4:0]  rs;
    logic [47:0] w;
    logic [23:0] t;
    logic        inc;
    e = v[30:23];
    rs = 5'(8'd150 - e);
    w = {1'b1, v[22:0], 24'd0} >> rs;
    t = w[47:24];
    inc = w[23] & ((|w[22:0]) | t[0]);
    if (e == 8'hFF && v[22:0] != 23'd0) begin
      return CODE_MAX;
    end
    if (v[31] || v[30:0] == 31'd0) begin
      return 7'd0;
    end
    if (v[30:0] >= FP_127[30:0]) begin
      return CODE_MAX;
    end
    if (e < 8'd126) begin
      return 7'd0;
    end
    return 7'(t + {23'd0, inc});
  endfunction

endpackage

FILE: rtl/core/uq7_fmul.sv
module uq7_fmul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  input  logic              byp_i,
  input  uq7_pkg::side_t    side_i,
  output logic [31:0]       res_o,
  output uq7_pkg::side_t    side_o
);

  // Stage 1: unpack, specials, mantissa product
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic [7:0]  ea, eb;
  logic [47:0] prod;
  logic        spec_d;
  logic [31:0] spec_val_d;
  logic [9:0]  e0_d;

  always_comb begin
    ea     = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb     = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    a_inf  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    a_zero = (a_i[30:0] == 31'd0);
    b_zero = (b_i[30:0] == 31'd0);
    sgn    = a_i[31] ^ b_i[31];
    prod   = {(a_i[30:23] != 8'd0), a_i[22:0]} * {(b_i[30:23] != 8'd0), b_i[22:0]};
    e0_d   = {2'd0, ea} + {2'd0, eb} - 10'd126;
    spec_d = byp_i | a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
    if (byp_i) begin
      spec_val_d = a_i;
    end else if (a_nan) begin
      spec_val_d = a_i | uq7_pkg::FP_QUIET_BIT;
    end else if (b_nan) begin
      spec_val_d = b_i | uq7_pkg::FP_QUIET_BIT;
    end else if ((a_inf & b_zero) | (a_zero & b_inf)) begin
      spec_val_d = uq7_pkg::FP_DFLT_NAN;
    end else if (a_inf | b_inf) begin
      spec_val_d = {sgn, 8'hFF, 23'd0};
    end else begin
      spec_val_d = {sgn, 31'd0};
    end
  end

  logic [47:0]    p1_q, p2_q;
  logic [9:0]     e1_q, e2_q, ex3_q;
  logic           s1_q, s2_q, s3_q, sp1_q, sp2_q, sp3_q;
  logic [31:0]    sv1_q, sv2_q, sv3_q, res_q;
  logic [5:0]     lz2_q;
  logic [47:0]    q3_q;
  logic           st3_q;
  uq7_pkg::side_t sd1_q, sd2_q, sd3_q, sd4_q;

  // Stage 3: exponent limit and normalizing or denormalizing shift
  logic [9:0]  lim, rsh_w, ex_d;
  logic [5:0]  lsh;
  logic [95:0] wide;
  logic [47:0] q_d;
  logic        st_d, ge1;

  always_comb begin
    ge1   = !e2_q[9] && (e2_q != 10'd0);
    lim   = e2_q - 10'd1;
    lsh   = ({4'd0, lz2_q} <= lim) ? lz2_q : lim[5:0];
    rsh_w = 10'd1 - e2_q;
    wide  = {p2_q, 48'd0} >> rsh_w[6:0];
    if (ge1) begin
      q_d  = p2_q << lsh;
      st_d = 1'b0;
      ex_d = e2_q - {4'd0, lsh};
    end else begin
      q_d  = wide[95:48];
      st_d = |wide[47:0];
      ex_d = 10'd1;
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= prod;
      e1_q  <= e0_d;
      s1_q  <= sgn;
      sp1_q <= spec_d;
      sv1_q <= spec_val_d;
      p2_q  <= p1_q;
      e2_q  <= e1_q;
      s2_q  <= s1_q;
      sp2_q <= sp1_q;
      sv2_q <= sv1_q;
      lz2_q <= uq7_pkg::lzc48(p1_q);
      q3_q  <= q_d;
      st3_q <= st_d;
      ex3_q <= ex_d;
      s3_q  <= s2_q;
      sp3_q <= sp2_q;
      sv3_q <= sv2_q;
      res_q <= sp3_q ? sv3_q
                     : uq7_pkg::round_pack(s3_q, ex3_q, q3_q[47:24], q3_q[23],
                                           (|q3_q[22:0]) | st3_q);
    end
  end

  // Control beside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd1_q <= '0;
      sd2_q <= '0;
      sd3_q <= '0;
      sd4_q <= '0;
    end else if (en_i) begin
      sd1_q <= side_i;
      sd2_q <= sd1_q;
      sd3_q <= sd2_q;
      sd4_q <= sd3_q;
    end
  end

  assign res_o  = res_q;
  assign side_o = sd4_q;

endmodule

FILE: rtl/core/uq7_fadd.sv
module uq7_fadd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  input  logic              byp_i,
  input  uq7_pkg::side_t    side_i,
  output logic [31:0]       res_o,
  output uq7_pkg::side_t    side_o
);

  // Stage 1: specials, magnitude order, exponent difference
  logic        a_nan, b_nan, a_inf, b_inf, a_big;
  logic [31:0] big, sml;
  logic [7:0]  eb_big, eb_sml;
  logic        spec_d;
  logic [31:0] spec_val_d;

  always_comb begin
    a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    a_inf  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    a_big  = (a_i[30:0] >= b_i[30:0]);
    big    = a_big ? a_i : b_i;
    sml    = a_big ? b_i : a_i;
    eb_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    eb_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    spec_d = byp_i | a_nan | b_nan | a_inf | b_inf;
    if (byp_i) begin
      spec_val_d = a_i;
    end else if (a_nan) begin
      spec_val_d = a_i | uq7_pkg::FP_QUIET_BIT;
    end else if (b_nan) begin
      spec_val_d = b_i | uq7_pkg::FP_QUIET_BIT;
    end else if (a_inf & b_inf & (a_i[31] != b_i[31])) begin
      spec_val_d = uq7_pkg::FP_DFLT_NAN;
    end else if (a_inf) begin
      spec_val_d = a_i;
    end else begin
      spec_val_d = b_i;
    end
  end

  logic [23:0]    mb1_q, ms1_q;
  logic [7:0]     e1_q, d1_q, e2_q, e3_q;
  logic           s1_q, sub1_q, s2_q, s3_q, sp1_q, sp2_q, sp3_q;
  logic [31:0]    sv1_q, sv2_q, sv3_q, res_q;
  logic [27:0]    r2_q, r3_q;
  logic [4:0]     lz3_q;
  uq7_pkg::side_t sd1_q, sd2_q, sd3_q, sd4_q;

  // Stage 2: align the smaller operand with sticky, then add or subtract
  logic [53:0] al;
  logic [26:0] sm;
  logic [27:0] r_d;
  logic        zs_d;

  always_comb begin
    al  = {ms1_q, 3'd0, 27'd0} >> d1_q;
    sm  = al[53:27] | {26'd0, |al[26:0]};
    r_d = sub1_q ? ({1'b0, mb1_q, 3'd0} - {1'b0, sm})
                 : ({1'b0, mb1_q, 3'd0} + {1'b0, sm});
    // exact cancellation rounds to plus zero
    zs_d = sub1_q ? 1'b0 : s1_q;
  end

  // Stage 4: normalize and round
  logic [4:0]  lsh;
  logic [27:0] q;
  logic [9:0]  ex;
  logic [31:0] sum;

  always_comb begin
    lsh = ({3'd0, lz3_q} <= e3_q) ? lz3_q : e3_q[4:0];
    q   = r3_q << lsh;
    ex  = {2'd0, e3_q} + 10'd1 - {5'd0, lsh};
    if (r3_q == 28'd0) begin
      sum = {s3_q, 31'd0};
    end else begin
      sum = uq7_pkg::round_pack(s3_q, ex, q[27:4], q[3], |q[2:0]);
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mb1_q  <= {(big[30:23] != 8'd0), big[22:0]};
      ms1_q  <= {(sml[30:23] != 8'd0), sml[22:0]};
      e1_q   <= eb_big;
      d1_q   <= eb_big - eb_sml;
      s1_q   <= big[31];
      sub1_q <= a_i[31] ^ b_i[31];
      sp1_q  <= spec_d;
      sv1_q  <= spec_val_d;
      r2_q   <= r_d;
      e2_q   <= e1_q;
      s2_q   <= (r_d == 28'd0) ? zs_d : s1_q;
      sp2_q  <= sp1_q;
      sv2_q  <= sv1_q;
      r3_q   <= r2_q;
      lz3_q  <= uq7_pkg::lzc28(r2_q);
      e3_q   <= e2_q;
      s3_q   <= s2_q;
      sp3_q  <= sp2_q;
      sv3_q  <= sv2_q;
      res_q  <= sp3_q ? sv3_q : sum;
    end
  end

  // Control beside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd1_q <= '0;
      sd2_q <= '0;
      sd3_q <= '0;
      sd4_q <= '0;
    end else if (en_i) begin
      sd1_q <= side_i;
      sd2_q <= sd1_q;
      sd3_q <= sd2_q;
      sd4_q <= sd3_q;
    end
  end

  assign res_o  = res_q;
  assign side_o = sd4_q;

endmodule

FILE: rtl/core/uq7_outbuf.sv
module uq7_outbuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_vld_i,
  input  uq7_pkg::out_item_t    in_item_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output uq7_pkg::out_item_t    out_item_o
);

  logic               out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic               load_out, load_skid, from_skid, pop;
  uq7_pkg::out_item_t out_q, skid_q;

  assign pop = out_v_q & out_ready_i;

  // Output register with one skid entry behind it
  always_comb begin
    out_v_d   = out_v_q;
    skid_v_d  = skid_v_q;
    load_out  = 1'b0;
    load_skid = 1'b0;
    from_skid = 1'b0;
    if (pop || !out_v_q) begin
      if (skid_v_q) begin
        out_v_d   = 1'b1;
        skid_v_d  = 1'b0;
        from_skid = 1'b1;
      end else begin
        out_v_d  = in_vld_i;
        load_out = in_vld_i;
      end
    end else if (in_vld_i && !skid_v_q) begin
      skid_v_d  = 1'b1;
      load_skid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (from_skid) begin
      out_q <= skid_q;
    end else if (load_out) begin
      out_q <= in_item_i;
    end
    if (load_skid) begin
      skid_q <= in_item_i;
    end
  end

  assign in_ready_o  = ~skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // skid entry only ever sits behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry without output entry");

  // skid fills only when the output was stalled
  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid filled without stall");
`endif

endmodule

FILE: rtl/core/uniform_uint7_quantizer.sv
// Uniform 7-bit scalar quantizer for fp32 vector elements.
// Input channel (in_valid_i / in_ready_o) carries cmd_i, operand_i, last_i:
//   quantize: code = nearbyint(x*scale + bias) clamped to 0..127, NaN -> 127
//   dequantize: fp32 (int8 - bias) * recip
//   rescale: fp32 x * recip_sq
// Output channel (out_valid_o / out_ready_i) returns result_o, status_o and
// last_out_o, one transaction per input, in order. status_o is set and
// result_o is zero when scale is not finite and positive or bias not finite.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write them only while idle, the block does not enforce it. Throughput:
// one element per cycle while in_ready_o is high. Path: input register,
// multiplier, adder, multiplier of 4 stages each, output register.
// When the receiver stalls, one more result lands in a skid entry and the
// pipeline freezes with in_ready_o low until that entry drains.
// Reset empties the pipeline and loads scale, bias, recip with 0 and
// recip_sq with 1.0.
module uniform_uint7_quantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] operand_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_o,
  output logic        status_o,
  output logic        last_out_o
);

  logic [31:0] scale_q, bias_q, recip_q, inv_sq_q;
  logic        cfg_ok, en;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= 32'd0;
      bias_q      <= 32'd0;
      recip_q     <= 32'd0;
      inv_sq_q    <= uq7_pkg::FP_ONE;
    end else if (cfg_we_i) begin
      case (uq7_pkg::reg_e'(cfg_idx_i))
        uq7_pkg::REG_SCALE:     scale_q     <= cfg_wdata_i;
        uq7_pkg::REG_BIAS:      bias_q      <= cfg_wdata_i;
        uq7_pkg::REG_RECIP:     recip_q     <= cfg_wdata_i;
        uq7_pkg::REG_INV_SQ:    inv_sq_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_ok = !scale_q[31] && (scale_q[30:0] != 31'd0) && (scale_q[30:23] != 8'hFF)
                  && (bias_q[30:23] != 8'hFF);

  // Input register; dequantize converts the byte here
  uq7_pkg::side_t f_side_q, a_side, b_side, c_side;
  logic [31:0]    f_op_q, a_res, b_res, c_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_side_q <= '0;
    end else if (en) begin
      f_side_q <= '{vld: in_valid_i, cmd: uq7_pkg::cmd_e'(cmd_i), last: last_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_op_q <= (uq7_pkg::cmd_e'(cmd_i) == uq7_pkg::CMD_DEQUANT)
                ? uq7_pkg::i8_to_fp(operand_i[7:0]) : operand_i;
    end
  end

  // First multiplier: x*scale or x*recip_sq
  uq7_fmul u_mul_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .a_i    (f_op_q),
    .b_i    ((f_side_q.cmd == uq7_pkg::CMD_QUANT) ? scale_q : inv_sq_q),
    .byp_i  (f_side_q.cmd != uq7_pkg::CMD_QUANT && f_side_q.cmd != uq7_pkg::CMD_RESCALE),
    .side_i (f_side_q),
    .res_o  (a_res),
    .side_o (a_side)
  );

  // Adder: prod + bias, or int - bias
  uq7_fadd u_add (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .a_i    (a_res),
    .b_i    ((a_side.cmd == uq7_pkg::CMD_DEQUANT) ? {~bias_q[31], bias_q[30:0]} : bias_q),
    .byp_i  (a_side.cmd != uq7_pkg::CMD_QUANT && a_side.cmd != uq7_pkg::CMD_DEQUANT),
    .side_i (a_side),
    .res_o  (b_res),
    .side_o (b_side)
  );

  // Second multiplier: difference times recip
  uq7_fmul u_mul_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .a_i    (b_res),
    .b_i    (recip_q),
    .byp_i  (b_side.cmd != uq7_pkg::CMD_DEQUANT),
    .side_i (b_side),
    .res_o  (c_res),
    .side_o (c_side)
  );

  // Final selection: code, fp32 value, or zero
  uq7_pkg::out_item_t fin, out_item;
  always_comb begin
    fin.status = ~cfg_ok;
    fin.last   = c_side.last;
    if (!cfg_ok) begin
      fin.result = 32'd0;
    end else begin
      case (c_side.cmd)
        uq7_pkg::CMD_QUANT:   fin.result = {25'd0, uq7_pkg::to_code(c_res)};
        uq7_pkg::CMD_DEQUANT: fin.result = c_res;
        uq7_pkg::CMD_RESCALE: fin.result = c_res;
        default:              fin.result = 32'd0;
      endcase
    end
  end

  uq7_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (c_side.vld & en),
    .in_item_i   (fin),
    .in_ready_o  (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item)
  );

  assign in_ready_o = en;
  assign result_o   = out_item.result;
  assign status_o   = out_item.status;
  assign last_out_o = out_item.last;

`ifndef SYNTHESIS
  // an invalid configuration never leaks a nonzero result
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (result_o == 32'd0))
    else $error("nonzero result with error status");
`endif

endmodule

FILE: test/uq7_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts every result and compares it
module uq7_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] operand_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] result_i,
  input  logic        status_i,
  input  logic        last_out_i,
  output int          err_cnt_o,
  output int          pending_o
);

  localparam logic [31:0] NAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [31:0] NAN_QUIET   = 32'h0040_0000;
  localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;

  logic [31:0]        scale_q, bias_q, recip_q, inv_sq_q;
  uq7_pkg::out_item_t expected_q[$];

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  // Significand and exponent of the weight of its lsb
  function automatic void fp_split(input logic [31:0] a, output logic [23:0] m,
                                   output int e);
    if (a[30:23] == 8'd0) begin
      m = {1'b0, a[22:0]};
      e = -149;
    end else begin
      m = {1'b1, a[22:0]};
      e = int'(a[30:23]) - 150;
    end
  endfunction

  // Round mag * 2^ex to fp32, nearest even, with gradual underflow
  function automatic logic [31:0] fp_round(input logic s, input logic [127:0] mag,
                                           input int ex);
    int           p, lsb, sh;
    logic [127:0] keep;
    logic         g, st;
    if (mag == 128'd0) return {s, 31'd0};
    p = 0;
    for (int i = 0; i < 128; i++) if (mag[i]) p = i;
    lsb = (p + ex < -126) ? -149 : p + ex - 23;
    sh = lsb - ex;
    if (sh >= 128) begin
      keep = 128'd0;
    end else if (sh > 0) begin
      keep = mag >> sh;
      g = mag[sh-1];
      st = (sh > 1) ? |(mag & ((128'd1 << (sh - 1)) - 128'd1)) : 1'b0;
      if (g && (st || keep[0])) keep = keep + 128'd1;
    end else begin
      keep = mag << (-sh);
    end
    if (keep[24]) begin
      keep = keep >> 1;
      lsb++;
    end
    if (!keep[23]) return {s, 8'd0, keep[22:0]};
    if (lsb + 150 >= 255) return {s, 8'hFF, 23'd0};
    return {s, 8'(lsb + 150), keep[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic [23:0] ma, mb;
    int          ea, eb;
    logic        s;
    s = a[31] ^ b[31];
    if (is_nan(a)) return a | NAN_QUIET;
    if (is_nan(b)) return b | NAN_QUIET;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return NAN_DEFAULT;
      return {s, 8'hFF, 23'd0};
    end
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    return fp_round(s, {104'd0, ma} * {104'd0, mb}, ea + eb);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [23:0]  ma, mb, mt;
    int           ea, eb, et, d, ex;
    logic         sa, sb, st, s;
    logic [127:0] big, sml, mag;
    if (is_nan(a)) return a | NAN_QUIET;
    if (is_nan(b)) return b | NAN_QUIET;
    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return NAN_DEFAULT;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    sa = a[31];
    sb = b[31];
    // keep the larger exponent in a
    if (ea < eb) begin
      mt = ma; ma = mb; mb = mt;
      et = ea; ea = eb; eb = et;
      st = sa; sa = sb; sb = st;
    end
    d = ea - eb;
    if (d > 60) begin
      // far smaller operand only matters as a sticky bit
      big = {104'd0, ma} << 60;
      sml = (mb != 24'd0) ? 128'd1 : 128'd0;
      ex = ea - 60;
    end else begin
      big = {104'd0, ma} << d;
      sml = {104'd0, mb};
      ex = eb;
    end
    if (sa == sb) begin
      mag = big + sml;
      s = sa;
    end else if (big >= sml) begin
      mag = big - sml;
      s = sa;
    end else begin
      mag = sml - big;
      s = sb;
    end
    if (mag == 128'd0) return 32'd0;
    return fp_round(s, mag, ex);
  endfunction

  // Nearest even integer clamped to 0..127, NaN to the top code
  function automatic logic [31:0] code_of(input logic [31:0] v);
    logic [23:0] m;
    logic [63:0] t, m64;
    int          e, sh;
    logic        g, st;
    if (is_nan(v)) return 32'd127;
    if (v[31] || v[30:0] == 31'd0) return 32'd0;
    if (v[30:0] >= 31'h42FE_0000) return 32'd127;
    fp_split(v, m, e);
    sh = -e;
    if (sh >= 40) return 32'd0;
    m64 = {40'd0, m};
    t = m64 >> sh;
    g = m64[sh-1];
    st = (sh > 1) ? |(m64 & ((64'd1 << (sh - 1)) - 64'd1)) : 1'b0;
    if (g && (st || t[0])) t = t + 64'd1;
    return t[31:0];
  endfunction

  function automatic uq7_pkg::out_item_t predict_item(input uq7_pkg::cmd_e cmd,
                                                      input logic [31:0] op,
                                                      input logic last);
    uq7_pkg::out_item_t r;
    logic [7:0]         mag8;
    logic [31:0]        xf;
    r.result = 32'd0;
    r.status = 1'b0;
    r.last   = last;
    if (scale_q[31] || scale_q[30:0] == 31'd0 || scale_q[30:23] == 8'hFF ||
        bias_q[30:23] == 8'hFF) begin
      r.status = 1'b1;
    end else begin
      case (cmd)
        uq7_pkg::CMD_QUANT: r.result = code_of(fp_add(fp_mul(op, scale_q), bias_q));
        uq7_pkg::CMD_DEQUANT: begin
          mag8 = op[7] ? 8'(-op[7:0]) : op[7:0];
          xf = fp_round(op[7], {120'd0, mag8}, 0);
          r.result = fp_mul(fp_add(xf, bias_q ^ SIGN_BIT), recip_q);
        end
        uq7_pkg::CMD_RESCALE: r.result = fp_mul(op, inv_sq_q);
        default: r.result = 32'd0;
      endcase
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  // Register shadow, prediction on input, comparison on output
  always @(posedge clk_i or negedge rst_ni) begin
    uq7_pkg::out_item_t exp_item;
    if (!rst_ni) begin
      scale_q     <= 32'd0;
      bias_q      <= 32'd0;
      recip_q     <= 32'd0;
      inv_sq_q    <= 32'h3F80_0000;
      expected_q.delete();
      err_cnt_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (uq7_pkg::reg_e'(cfg_idx_i))
          uq7_pkg::REG_SCALE:  scale_q  <= cfg_wdata_i;
          uq7_pkg::REG_BIAS:   bias_q   <= cfg_wdata_i;
          uq7_pkg::REG_RECIP:  recip_q  <= cfg_wdata_i;
          uq7_pkg::REG_INV_SQ: inv_sq_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(predict_item(uq7_pkg::cmd_e'(cmd_i), operand_i, last_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          err_cnt_o <= err_cnt_o + 1;
          $display("%0t: unexpected transaction result=%h status=%b last=%b",
                   $time, result_i, status_i, last_out_i);
        end else begin
          exp_item = expected_q.pop_front();
          if (exp_item.result !== result_i || exp_item.status !== status_i ||
              exp_item.last !== last_out_i) begin
            err_cnt_o <= err_cnt_o + 1;
            $display("%0t: mismatch exp res=%h st=%b last=%b, act res=%h st=%b last=%b",
                     $time, exp_item.result, exp_item.status, exp_item.last,
                     result_i, status_i, last_out_i);
          end
        end
      end
    end
  end

endmodule

FILE: test/uniform_uint7_quantizer_test.sv
`timescale 1ns / 100ps

module uniform_uint7_quantizer_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  cmd_i;
  logic [31:0] operand_i;
  logic        last_i;
  logic        out_valid_o, out_ready_i;
  logic [31:0] result_o;
  logic        status_o, last_out_o;
  int          err_cnt, pending;
  int          quiet_cycles;
  logic        stall_en, gaps_en, hold_req;
  logic [31:0] cur_scale, cur_bias;

  uniform_uint7_quantizer u_dut (.*);

  uq7_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .operand_i, .last_i,
    .out_valid_i(out_valid_o), .out_ready_i, .result_i(result_o),
    .status_i(status_o), .last_out_i(last_out_o),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (stall_en && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic write_cfg(input logic [31:0] sc, input logic [31:0] bi,
                           input logic [31:0] inv, input logic [31:0] inv_sq);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= uq7_pkg::REG_SCALE;
    cfg_wdata_i <= sc;
    @(posedge clk_i);
    cfg_idx_i   <= uq7_pkg::REG_BIAS;
    cfg_wdata_i <= bi;
    @(posedge clk_i);
    cfg_idx_i   <= uq7_pkg::REG_RECIP;
    cfg_wdata_i <= inv;
    @(posedge clk_i);
    cfg_idx_i   <= uq7_pkg::REG_INV_SQ;
    cfg_wdata_i <= inv_sq;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_scale = sc;
    cur_bias  = bi;
  endtask

  // Offer one transaction and wait for it to be taken; valid stays high unless a random gap follows
  task automatic send(input uq7_pkg::cmd_e cmd, input logic [31:0] op, input logic last);
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    operand_i  <= op;
    last_i     <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (gaps_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] special_fp();
    case ($urandom_range(0, 12))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return 32'h7FC0_0000;
      5: return 32'h7F80_0001;
      6: return 32'hFFFF_FFFF;
      7: return 32'h0000_0001;
      8: return 32'h807F_FFFF;
      9: return 32'h7F7F_FFFF;
      10: return 32'h3F00_0000;
      11: return 32'h3FC0_0000;
      default: return 32'h4020_0000;
    endcase
  endfunction

  // Operands mostly aimed at codes and rounding ties of the current setting
  function automatic logic [31:0] pick_operand();
    real     y, s, b;
    int      sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return $urandom;
    if (sel == 1) return special_fp();
    s = $bitstoshortreal(cur_scale);
    b = $bitstoshortreal(cur_bias);
    y = $urandom_range(0, 300) / 2.0 - 10.0;
    if ($urandom_range(0, 2) == 0) y = y + $urandom_range(0, 999) / 1000.0;
    return $shortrealtobits(shortreal'((y - b) / s));
  endfunction

  task automatic run_items(input int n);
    uq7_pkg::cmd_e cmd;
    for (int i = 0; i < n; i++) begin
      cmd = uq7_pkg::cmd_e'($urandom_range(0, 3));
      send(cmd, (cmd == uq7_pkg::CMD_DEQUANT) ? $urandom : pick_operand(), 1'($urandom));
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    send(uq7_pkg::CMD_QUANT, 32'h3F00_0000, 1'b0);   // 0.5 ties down to 0
    send(uq7_pkg::CMD_QUANT, 32'h3FC0_0000, 1'b0);   // 1.5 ties up to 2
    send(uq7_pkg::CMD_QUANT, 32'h4020_0000, 1'b0);   // 2.5 ties down to 2
    send(uq7_pkg::CMD_QUANT, 32'h42FD_0000, 1'b0);   // 126.5
    send(uq7_pkg::CMD_QUANT, 32'h42FF_0000, 1'b1);   // 127.5 clamps
    send(uq7_pkg::CMD_QUANT, 32'h8000_0000, 1'b0);   // negative zero
    send(uq7_pkg::CMD_QUANT, 32'hBF80_0000, 1'b0);   // negative
    send(uq7_pkg::CMD_QUANT, 32'h7FC0_0000, 1'b0);   // NaN gives top code
    send(uq7_pkg::CMD_QUANT, 32'h7F80_0000, 1'b0);
    send(uq7_pkg::CMD_QUANT, 32'hFF80_0000, 1'b0);
    send(uq7_pkg::CMD_QUANT, 32'h7149_F2CA, 1'b0);
    send(uq7_pkg::CMD_QUANT, 32'h0000_0001, 1'b1);
    send(uq7_pkg::CMD_DEQUANT, 32'hFFFF_FF80, 1'b0); // -128 with upper bits set
    send(uq7_pkg::CMD_DEQUANT, 32'h0000_007F, 1'b0);
    send(uq7_pkg::CMD_DEQUANT, 32'hABCD_EF00, 1'b0);
    send(uq7_pkg::CMD_DEQUANT, 32'h5A5A_5AFF, 1'b1);
    send(uq7_pkg::CMD_RESCALE, 32'h7FC0_0000, 1'b0);
    send(uq7_pkg::CMD_RESCALE, 32'hFF80_0000, 1'b0);
    send(uq7_pkg::CMD_RESCALE, 32'h7F7F_FFFF, 1'b0);
    send(uq7_pkg::CMD_RESCALE, 32'h807F_FFFF, 1'b0);
    send(uq7_pkg::CMD_NONE, 32'hFFFF_FFFF, 1'b1);
    send(uq7_pkg::CMD_NONE, 32'h0000_0000, 1'b0);
    in_valid_i <= 1'b0;
  endtask

  initial begin
    shortreal sc, bi;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = uq7_pkg::REG_SCALE;
    cfg_wdata_i = 32'd0;
    in_valid_i  = 1'b0;
    cmd_i       = uq7_pkg::CMD_QUANT;
    operand_i   = 32'd0;
    last_i      = 1'b0;
    quiet_cycles = 0;
    stall_en    = 1'b1;
    gaps_en     = 1'b1;
    hold_req    = 1'b0;
    cur_scale   = 32'd0;
    cur_bias    = 32'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting has scale zero, so every transaction reports invalid
    run_items(60);
    write_cfg(uq7_pkg::FP_ONE, 32'd0, uq7_pkg::FP_ONE, uq7_pkg::FP_ONE);
    run_directed();
    write_cfg(32'h427E_0000, 32'h427E_0000, $shortrealtobits(shortreal'(1.0 / 63.5)),
              $shortrealtobits(shortreal'(1.0 / (63.5 * 63.5))));
    run_items(150);
    // extremes of range
    write_cfg(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h7F7F_FFFF);
    run_items(100);
    write_cfg(32'h0000_0001, 32'h0000_0000, 32'h7F80_0000, 32'h0000_0000);
    run_items(100);
    // invalid settings, then NaN in recip and recip_sq
    write_cfg(uq7_pkg::FP_ONE, 32'h7F80_0000, uq7_pkg::FP_ONE, uq7_pkg::FP_ONE);
    run_items(40);
    write_cfg(32'h7FC0_0000, 32'd0, uq7_pkg::FP_ONE, uq7_pkg::FP_ONE);
    run_items(40);
    write_cfg(32'h8000_0000, 32'hFFFF_FFFF, uq7_pkg::FP_ONE, uq7_pkg::FP_ONE);
    run_items(40);
    write_cfg(32'hBF80_0000, 32'h3F00_0000, uq7_pkg::FP_ONE, uq7_pkg::FP_ONE);
    run_items(40);
    write_cfg(uq7_pkg::FP_ONE, 32'd0, 32'h7FC0_0001, 32'hFFFF_FFFF);
    run_items(80);

    // long receiver hold while the sender keeps offering
    write_cfg(32'h4200_0000, 32'h4180_0000, $shortrealtobits(shortreal'(1.0 / 32.0)),
              $shortrealtobits(shortreal'(1.0 / 1024.0)));
    gaps_en  = 1'b0;
    hold_req = 1'b1;
    run_items(150);
    gaps_en  = 1'b1;

    // random settings, mostly sensible ones
    for (int p = 0; p < 6; p++) begin
      if (p % 3 == 2) begin
        write_cfg($urandom, $urandom, $urandom, $urandom);
      end else begin
        sc = shortreal'($urandom_range(1, 4000) / 20.0);
        bi = shortreal'($urandom_range(0, 3000) / 20.0 - 50.0);
        write_cfg($shortrealtobits(sc), $shortrealtobits(bi),
                  $shortrealtobits(shortreal'(1.0 / sc)),
                  $shortrealtobits(shortreal'(1.0 / (sc * sc))));
      end
      run_items(150);
    end

    // closing stretch without any idling
    write_cfg(32'h4300_0000, 32'hC000_0000, 32'h3C00_0000, 32'h3880_0000);
    stall_en = 1'b0;
    gaps_en  = 1'b0;
    run_items(200);

    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
